// ===== hw/rtl/bb3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, constants and the divide-by-count reciprocal table for the
// 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

   localparam int MAX_WIDTH_DEF    = 1024;
   localparam int FRAME_WIDTH_W    = 11;
   localparam int FRAME_HEIGHT_W   = 12;
   localparam int CSR_DATA_W       = 12;
   localparam int PIXEL_W          = 24;
   localparam int SUM_W            = 12;
   localparam int RECIP_W          = 16;
   localparam int RECIP_SHIFT      = 15;

   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd1024;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 12'd768;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic       action;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       frame_end;
   } rsp_type;

   // ceil(2^15 / count); exact floor quotient for sums up to 9 * 255
   function automatic logic [RECIP_W-1:0] recip(input logic [3:0] count);
      logic [RECIP_W-1:0] r;
      begin
         case (count)
            4'd1:    r = 16'd32768;
            4'd2:    r = 16'd16384;
            4'd3:    r = 16'd10923;
            4'd4:    r = 16'd8192;
            4'd6:    r = 16'd5462;
            4'd9:    r = 16'd3641;
            default: r = 16'd32768;
         endcase
         return r;
      end
   endfunction

endpackage

// ===== hw/rtl/bb3_line_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_line_mem
// Line store pair as one synchronous memory, registered read data, with
// forwarding of a write that lands on the address read in the same cycle.
// ----------------------------------------------------------------------------
module bb3_line_mem #(
   parameter int DEPTH = bb3_pkg::MAX_WIDTH_DEF,
   parameter int DW    = 2 * bb3_pkg::PIXEL_W,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_q_ff;
   logic [DW-1:0] fwd_data_ff;
   logic          fwd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff     <= mem[rd_addr];
         fwd_hit_ff  <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rd_q_ff;

endmodule

// ===== hw/rtl/box_blur_3x3_rgb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// 3x3 box blur of a raster-order RGB pixel stream.
// ----------------------------------------------------------------------------
// Takes one request per clock unless a held result stalls it, a rate set by
// the line memory, which is read once and written once per request, and returns at
// most one result per request; a pixel's blurred value leaves with the request
// that arrives width+1 requests after it, so flush requests (action = 1) drain
// the last width+1 results once the frame's last pixel is in, and the frame's
// last result carries frame_end. A request passes the memory, sum and multiply
// stages to the result register. Line memory needs no clearing after reset.
// Writing either register restarts the frame.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
   parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bb3_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bb3_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_wen,
   input  bb3_pkg::csr_index_type            csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = bb3_pkg::FRAME_HEIGHT_W;
   localparam int RW = HW + 1;
   localparam int PW = bb3_pkg::PIXEL_W;
   localparam int SW = bb3_pkg::SUM_W;
   localparam int MW = bb3_pkg::SUM_W + bb3_pkg::RECIP_W;

   // configuration
   logic [bb3_pkg::FRAME_WIDTH_W-1:0] frame_width_ff;
   logic [HW-1:0]                     frame_height_ff;
   logic [WW-1:0]                     w_eff;
   logic [HW-1:0]                     h_eff;
   logic                              width_over;

   // position counters
   logic [WW-1:0] in_col_ff, in_col_in;
   logic [RW-1:0] in_row_ff, in_row_in;
   logic [WW-1:0] out_col_ff, out_col_in;
   logic [HW-1:0] out_row_ff, out_row_in;

   // request decode
   logic          en;
   logic          accept;
   logic          frame_in;
   logic          flush;
   logic          take;
   logic          emit;
   logic          col_wrap;
   logic          out_col_wrap;
   logic          last_out;
   logic [PW-1:0] pix;
   logic [WW-1:0] in_col_inc;
   logic [WW-1:0] out_col_inc;

   // stage 1: memory data returns
   logic          s1_valid_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [PW-1:0] s1_pix_ff;
   logic          s1_emit_ff;
   logic [3:0]    s1_mask_ff;
   logic          s1_end_ff;
   logic [2*PW-1:0] mem_rd_data;
   logic            mem_wr_en;

   logic [PW-1:0] win_ff [3][3];

   // stage 2: sum
   logic          s2_valid_ff;
   logic [3:0]    s2_mask_ff;
   logic          s2_end_ff;
   logic [2:0]    row_m;
   logic [2:0]    col_m;
   logic [1:0]    n_rows;
   logic [1:0]    n_cols;
   logic [3:0]    count;
   logic [SW-1:0] sum_c [3];

   // stage 3: reciprocal multiply
   logic                        s3_valid_ff;
   logic                        s3_end_ff;
   logic [SW-1:0]               s3_sum_ff [3];
   logic [bb3_pkg::RECIP_W-1:0] s3_recip_ff;
   logic [MW-1:0]               prod [3];

   logic             rsp_valid_ff;
   bb3_pkg::rsp_type rsp_payload_ff;

   // ---------------------------------------------------------------------
   assign width_over = ({{(32 - bb3_pkg::FRAME_WIDTH_W){1'b0}}, frame_width_ff}
                        > 32'(MAX_WIDTH));
   assign w_eff = (frame_width_ff == '0) ? WW'(1)
                : width_over ? WW'(MAX_WIDTH)
                : WW'(frame_width_ff);
   assign h_eff = (frame_height_ff == '0) ? HW'(1) : frame_height_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign accept    = req_valid && req_ready;

   assign frame_in = in_row_ff < {1'b0, h_eff};
   assign flush    = req_payload.action || !frame_in;
   assign take     = accept && !(req_payload.action && frame_in);
   assign pix      = flush ? '0
                   : {req_payload.red_in, req_payload.green_in, req_payload.blue_in};

   always_comb begin
      if (w_eff == WW'(1)) begin
         emit = in_row_ff >= RW'(2);
      end else begin
         emit = (in_row_ff >= RW'(2))
             || ((in_row_ff == RW'(1)) && (in_col_ff >= WW'(1)));
      end
   end

   assign in_col_inc   = in_col_ff + WW'(1);
   assign col_wrap     = in_col_inc >= w_eff;
   assign out_col_inc  = out_col_ff + WW'(1);
   assign out_col_wrap = out_col_inc >= w_eff;
   assign last_out     = emit && out_col_wrap
                      && ({1'b0, out_row_ff} + RW'(1) >= {1'b0, h_eff});

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_wen) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (take) begin
         in_col_in = col_wrap ? '0 : in_col_inc;
         in_row_in = col_wrap ? in_row_ff + RW'(1) : in_row_ff;
         if (emit) begin
            out_col_in = out_col_wrap ? '0 : out_col_inc;
            out_row_in = out_col_wrap ? out_row_ff + HW'(1) : out_row_ff;
         end
         if (last_out) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= bb3_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= bb3_pkg::FRAME_HEIGHT_RST;
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               bb3_pkg::CSR_FRAME_WIDTH:
                  frame_width_ff <= csr_wdata[bb3_pkg::FRAME_WIDTH_W-1:0];
               bb3_pkg::CSR_FRAME_HEIGHT:
                  frame_height_ff <= csr_wdata[HW-1:0];
               default: ;
            endcase
         end
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // ---------------------------------------------------------------------
   // stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (en && take) begin
         s1_addr_ff <= in_col_ff[AW-1:0];
         s1_pix_ff  <= pix;
         s1_emit_ff <= emit;
         s1_end_ff  <= last_out;
         // row above, row below, column left, column right
         s1_mask_ff <= {out_row_ff >= HW'(1),
                        {1'b0, out_row_ff} + RW'(1) < {1'b0, h_eff},
                        out_col_ff >= WW'(1),
                        out_col_inc < w_eff};
      end
   end

   assign mem_wr_en = en && s1_valid_ff;

   bb3_line_mem #(
      .DEPTH (MAX_WIDTH),
      .DW    (2 * PW)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (en && take),
      .rd_addr (in_col_ff[AW-1:0]),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data ({mem_rd_data[PW-1:0], s1_pix_ff})
   );

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= mem_rd_data[2*PW-1:PW];
         win_ff[1][2] <= mem_rd_data[PW-1:0];
         win_ff[2][2] <= s1_pix_ff;
      end
   end

   // ---------------------------------------------------------------------
   // stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_mask_ff <= s1_mask_ff;
         s2_end_ff  <= s1_end_ff;
      end
   end

   assign row_m  = {s2_mask_ff[2], 1'b1, s2_mask_ff[3]};
   assign col_m  = {s2_mask_ff[0], 1'b1, s2_mask_ff[1]};
   assign n_rows = 2'd1 + {1'b0, s2_mask_ff[3]} + {1'b0, s2_mask_ff[2]};
   assign n_cols = 2'd1 + {1'b0, s2_mask_ff[1]} + {1'b0, s2_mask_ff[0]};
   assign count  = n_rows * n_cols;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum_c[ch] = '0;
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               if (row_m[r] && col_m[k]) begin
                  sum_c[ch] = sum_c[ch] + SW'(win_ff[r][k][(2 - ch) * 8 +: 8]);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // stage 3
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_end_ff   <= s2_end_ff;
         s3_recip_ff <= bb3_pkg::recip(count);
         for (int ch = 0; ch < 3; ch++) begin
            s3_sum_ff[ch] <= sum_c[ch];
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch] = MW'(s3_sum_ff[ch]) * MW'(s3_recip_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_payload_ff.red_out   <= prod[0][bb3_pkg::RECIP_SHIFT +: 8];
         rsp_payload_ff.green_out <= prod[1][bb3_pkg::RECIP_SHIFT +: 8];
         rsp_payload_ff.blue_out  <= prod[2][bb3_pkg::RECIP_SHIFT +: 8];
         rsp_payload_ff.frame_end <= s3_end_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_out_row_in_frame : assert property (@(posedge clock) disable iff (reset)
      out_row_ff < h_eff)
      else $error("output row beyond frame height");

   a_out_col_in_row : assert property (@(posedge clock) disable iff (reset)
      out_col_ff < w_eff)
      else $error("output column beyond frame width");

   a_end_restarts : assert property (@(posedge clock) disable iff (reset)
      (take && last_out && !csr_wen) |=> (in_row_ff == '0 && out_row_ff == '0))
      else $error("frame end did not restart counters");

   a_result_order : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> (!mem_wr_en && !req_ready)
         ##1 (rsp_valid_ff && $stable(rsp_payload_ff)))
      else $error("pipeline advanced while result stalled");
`endif

endmodule
